[src/caenc_pkg.sv]
// Shared types, constants and polymod functions for the CashAddr address encoder.
package caenc_pkg;

	localparam int HASH_BYTES = 20;
	localparam int ADDR_CHARS = ((HASH_BYTES + 1) * 8 + 4) / 5 + 8;
	localparam int SEEN_W     = $clog2(HASH_BYTES + 1);
	localparam int QDEPTH     = 4;
	localparam int QPTR_W     = $clog2(QDEPTH);

	localparam logic [SEEN_W-1:0] SEEN_FULL = SEEN_W'(HASH_BYTES);
	localparam logic [SEEN_W-1:0] SEEN_LAST = SEEN_W'(HASH_BYTES - 1);
	localparam logic [7:0]        MIN_LEN   = 8'(ADDR_CHARS);
	localparam logic [7:0]        VER_P2SH  = 8'h08;
	localparam logic [7:0]        VER_P2PKH = 8'h00;

	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_LEN = 2'd1,
		ST_CAP = 2'd2
	} status_t;

	typedef enum logic [0:0] {
		CFG_ADDR_TYPE = 1'b0,
		CFG_MAX_LEN   = 1'b1
	} cfg_index_t;

	typedef enum logic [1:0] {
		ENT_BYTE  = 2'd0,
		ENT_FINAL = 2'd1,
		ENT_ERR   = 2'd2
	} entry_kind_t;

	typedef enum logic [1:0] {
		BK_RUN,
		BK_ZERO,
		BK_CHK
	} bk_state_t;

	typedef struct packed {
		logic [7:0] hash_byte;
		logic       last_byte;
	} hash_item_t;

	typedef struct packed {
		logic [6:0] address_char;
		logic       last_char;
		status_t    status;
	} char_item_t;

	typedef struct packed {
		entry_kind_t kind;
		logic        first;
		logic [7:0]  version;
		logic [7:0]  data;
		status_t     status;
	} entry_t;

	localparam logic [39:0] GEN_POLY [5] = '{
		40'h98f2bc8e61, 40'h79b76d99e2, 40'hf33e5fb3c4,
		40'hae2eabe2a8, 40'h1e4f43e470
	};

	localparam logic [4:0] NET_PREFIX [11] = '{
		5'd2, 5'd9, 5'd20, 5'd3, 5'd15, 5'd9, 5'd14, 5'd3, 5'd1, 5'd19, 5'd8
	};

	localparam logic [6:0] CHARSET [32] = '{
		7'h71, 7'h70, 7'h7a, 7'h72, 7'h79, 7'h39, 7'h78, 7'h38,
		7'h67, 7'h66, 7'h32, 7'h74, 7'h76, 7'h64, 7'h77, 7'h30,
		7'h73, 7'h33, 7'h6a, 7'h6e, 7'h35, 7'h34, 7'h6b, 7'h68,
		7'h63, 7'h65, 7'h36, 7'h6d, 7'h75, 7'h61, 7'h37, 7'h6c
	};

	function automatic logic [39:0] bch_step(input logic [39:0] c);
		logic [4:0]  top;
		logic [39:0] r;
		top = c[39:35];
		r   = {c[34:0], 5'b0};
		for (int k = 0; k < 5; k++) begin
			if (top[k]) begin
				r = r ^ GEN_POLY[k];
			end
		end
		return r;
	endfunction

	function automatic logic [39:0] prefix_start();
		logic [39:0] c;
		c = 40'd1;
		for (int k = 0; k < 11; k++) begin
			c = bch_step(c) ^ {35'b0, NET_PREFIX[k]};
		end
		return bch_step(c);
	endfunction

	localparam logic [39:0] POLY_INIT = prefix_start();

endpackage

[src/caenc_front.sv]
// Front end: accepts hash bytes, tracks length, classifies kept items into queue entries.
module caenc_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  hash_valid,
	output logic                  hash_ready,
	input  caenc_pkg::hash_item_t hash_item,
	input  logic                  addr_type,
	input  logic [7:0]            max_len,
	input  logic                  q_full,
	output logic                  q_push,
	output caenc_pkg::entry_t     q_entry
);
	import caenc_pkg::*;

	logic [SEEN_W-1:0] seen_q, seen_d;
	logic              err_q, err_d;
	logic              accept;

	assign hash_ready = !q_full;
	assign accept     = hash_valid && !q_full;

	always_comb begin
		seen_d          = seen_q;
		err_d           = err_q;
		q_push          = 1'b0;
		q_entry.kind    = ENT_BYTE;
		q_entry.first   = (seen_q == '0);
		q_entry.version = addr_type ? VER_P2SH : VER_P2PKH;
		q_entry.data    = hash_item.hash_byte;
		q_entry.status  = ST_OK;
		if (accept) begin
			if (!hash_item.last_byte) begin
				if (!err_q) begin
					if (seen_q >= SEEN_FULL) begin
						err_d = 1'b1;
					end else begin
						q_push = 1'b1;
						seen_d = seen_q + SEEN_W'(1);
					end
				end
			end else begin
				q_push = 1'b1;
				seen_d = '0;
				err_d  = 1'b0;
				if (err_q || seen_q != SEEN_LAST) begin
					q_entry.kind   = ENT_ERR;
					q_entry.status = ST_LEN;
				end else if (max_len < MIN_LEN) begin
					q_entry.kind   = ENT_ERR;
					q_entry.status = ST_CAP;
				end else begin
					q_entry.kind = ENT_FINAL;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			err_q  <= 1'b0;
		end else begin
			seen_q <= seen_d;
			err_q  <= err_d;
		end
	end

endmodule

[src/caenc_queue.sv]
// Short entry queue between the front end and the symbol back end.
module caenc_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  caenc_pkg::entry_t push_entry,
	output logic              full,
	output logic              valid,
	output caenc_pkg::entry_t head,
	input  logic              pop
);
	import caenc_pkg::*;

	entry_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_q, rd_q;
	logic [QPTR_W:0]    count_q;

	assign full  = (count_q == (QPTR_W+1)'(QDEPTH));
	assign valid = (count_q != '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QPTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QPTR_W+1)'(1);
			end
		end
	end

endmodule

[src/caenc_back.sv]
// Back end: regroups bits into symbols, runs the polymod, emits characters or errors.
module caenc_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  caenc_pkg::entry_t     q_head,
	output logic                  q_pop,
	output logic                  char_valid,
	input  logic                  char_ready,
	output caenc_pkg::char_item_t char_item
);
	import caenc_pkg::*;

	bk_state_t   state_q, state_d;
	logic [11:0] acc_q, acc_d;
	logic [3:0]  held_q, held_d;
	logic [39:0] poly_q, poly_d;
	logic [7:0]  pend_q, pend_d;
	logic        pend_v_q, pend_v_d;
	logic        fin_q, fin_d;
	logic [2:0]  cnt_q, cnt_d;
	logic        out_valid_q;
	char_item_t  out_item_q;
	logic        out_free;
	logic        emit;
	char_item_t  emit_item;
	logic        have_src;
	logic [11:0] src_acc;
	logic [3:0]  src_held;
	logic [2:0]  sh;
	logic [4:0]  sym;
	logic [4:0]  pad_sym;

	assign out_free   = !out_valid_q || char_ready;
	assign char_valid = out_valid_q;
	assign char_item  = out_item_q;

	always_comb begin
		state_d   = state_q;
		acc_d     = acc_q;
		held_d    = held_q;
		poly_d    = poly_q;
		pend_d    = pend_q;
		pend_v_d  = pend_v_q;
		fin_d     = fin_q;
		cnt_d     = cnt_q;
		q_pop     = 1'b0;
		emit      = 1'b0;
		emit_item = '{address_char: '0, last_char: 1'b0, status: ST_OK};
		have_src  = 1'b0;
		src_acc   = acc_q;
		src_held  = held_q;
		sh        = '0;
		sym       = '0;
		pad_sym   = 5'(acc_q[4:0] << (3'd5 - held_q[2:0]));
		unique case (state_q)
			BK_RUN: begin
				if (out_free) begin
					if (held_q >= 4'd5) begin
						have_src = 1'b1;
					end else if (pend_v_q) begin
						have_src = 1'b1;
						src_acc  = {acc_q[3:0], pend_q};
						src_held = held_q + 4'd8;
						pend_v_d = 1'b0;
					end else if (fin_q) begin
						if (held_q != '0) begin
							emit                   = 1'b1;
							emit_item.address_char = CHARSET[pad_sym];
							poly_d                 = bch_step(poly_q) ^ {35'b0, pad_sym};
						end
						acc_d   = '0;
						held_d  = '0;
						fin_d   = 1'b0;
						cnt_d   = '0;
						state_d = BK_ZERO;
					end else if (q_valid) begin
						q_pop = 1'b1;
						case (q_head.kind) inside
							ENT_BYTE, ENT_FINAL: begin
								have_src = 1'b1;
								fin_d    = (q_head.kind == ENT_FINAL);
								src_held = held_q + 4'd8;
								if (q_head.first) begin
									src_acc  = {acc_q[3:0], q_head.version};
									pend_d   = q_head.data;
									pend_v_d = 1'b1;
								end else begin
									src_acc = {acc_q[3:0], q_head.data};
								end
							end
							default: begin
								emit             = 1'b1;
								emit_item.last_char = 1'b1;
								emit_item.status = q_head.status;
								poly_d           = POLY_INIT;
								acc_d            = '0;
								held_d           = '0;
								pend_v_d         = 1'b0;
								fin_d            = 1'b0;
							end
						endcase
					end
					if (have_src) begin
						sh                     = 3'(src_held - 4'd5);
						sym                    = 5'(src_acc >> sh);
						acc_d                  = src_acc & ((12'd1 << sh) - 12'd1);
						held_d                 = src_held - 4'd5;
						poly_d                 = bch_step(poly_q) ^ {35'b0, sym};
						emit                   = 1'b1;
						emit_item.address_char = CHARSET[sym];
					end
				end
			end
			BK_ZERO: begin
				poly_d = bch_step(poly_q);
				cnt_d  = cnt_q + 3'd1;
				if (cnt_q == 3'd7) begin
					poly_d  = bch_step(poly_q) ^ 40'd1;
					state_d = BK_CHK;
				end
			end
			BK_CHK: begin
				if (out_free) begin
					emit                   = 1'b1;
					emit_item.address_char = CHARSET[poly_q[39:35]];
					emit_item.last_char    = (cnt_q == 3'd7);
					poly_d                 = {poly_q[34:0], 5'b0};
					cnt_d                  = cnt_q + 3'd1;
					if (cnt_q == 3'd7) begin
						poly_d  = POLY_INIT;
						state_d = BK_RUN;
					end
				end
			end
			default: begin
				state_d = BK_RUN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_RUN;
			acc_q       <= '0;
			held_q      <= '0;
			poly_q      <= POLY_INIT;
			pend_v_q    <= 1'b0;
			fin_q       <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			acc_q    <= acc_d;
			held_q   <= held_d;
			poly_q   <= poly_d;
			pend_v_q <= pend_v_d;
			fin_q    <= fin_d;
			cnt_q    <= cnt_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (char_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pend_q <= pend_d;
		if (emit) begin
			out_item_q <= emit_item;
		end
	end

endmodule

[src/cashaddr_address_encoder_top.sv]
// Top level of the CashAddr address encoder: configuration registers, front, queue and back.
//
//  channel | signals                          | item
//  hash    | hash_valid, hash_ready, hash_item | one hash byte, last_byte marks the end
//  char    | char_valid, char_ready, char_item | one address character or an error result
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | register write, always ready
//
// The front takes one byte per cycle while the 4-entry queue has room.
// The back emits one character per cycle while char_ready is high and it has bits to
// encode; an address of 20 bytes gives 34 data characters, then 8 polymod zero steps
// that emit nothing, then 8 checksum characters.
// Reset clears length tracking, the queue and the back end to the prefix state.
// A stalled char channel holds the back end; the queue then fills and lowers hash_ready.
module cashaddr_address_encoder_top (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  hash_valid,
	output logic                  hash_ready,
	input  caenc_pkg::hash_item_t hash_item,
	output logic                  char_valid,
	input  logic                  char_ready,
	output caenc_pkg::char_item_t char_item,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  caenc_pkg::cfg_index_t cfg_index,
	input  logic [7:0]            cfg_data
);
	import caenc_pkg::*;

	logic       addr_type_q;
	logic [7:0] max_len_q;
	logic       q_full;
	logic       q_push;
	logic       q_valid;
	logic       q_pop;
	entry_t     q_entry;
	entry_t     q_head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_type_q <= 1'b0;
			max_len_q   <= MIN_LEN;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_ADDR_TYPE: addr_type_q <= cfg_data[0];
				CFG_MAX_LEN:   max_len_q   <= cfg_data;
				default:       max_len_q   <= max_len_q;
			endcase
		end
	end

	caenc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.hash_valid (hash_valid),
		.hash_ready (hash_ready),
		.hash_item  (hash_item),
		.addr_type  (addr_type_q),
		.max_len    (max_len_q),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_entry    (q_entry)
	);

	caenc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.full       (q_full),
		.valid      (q_valid),
		.head       (q_head),
		.pop        (q_pop)
	);

	caenc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.char_item  (char_item)
	);

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full && hash_valid)
		else $error("queue push without room");

	a_pop_data: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue pop while empty");

	a_err_form: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && char_item.status != ST_OK
		|-> char_item.last_char && char_item.address_char == 7'd0)
		else $error("error result not final or carries a character");

endmodule
